[sv/dhp_pkg.sv]
// dhp_pkg: shared types and constants for the texture header parser
// used by dhp_front, dhp_queue, dhp_back and dds_header_parser
`timescale 1ns / 1ps
`default_nettype none

package dhp_pkg;

    localparam logic [31:0] MAGIC_DDS = 32'h2053_4444;
    localparam logic [31:0] HDR_BYTES = 32'd124;
    localparam logic [31:0] CC_DXT1   = 32'h3154_5844;
    localparam logic [31:0] CC_DXT3   = 32'h3354_5844;
    localparam logic [31:0] CC_DXT5   = 32'h3554_5844;

    localparam int FLAG_FOURCC_BIT = 2;
    localparam int FLAG_RGB_BIT    = 6;

    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_MAGIC  = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR    = 5'd1;
    localparam logic [POS_W-1:0] POS_HEIGHT = 5'd3;
    localparam logic [POS_W-1:0] POS_WIDTH  = 5'd4;
    localparam logic [POS_W-1:0] POS_MIPS   = 5'd7;
    localparam logic [POS_W-1:0] POS_FLAGS  = 5'd20;
    localparam logic [POS_W-1:0] POS_FOURCC = 5'd21;
    localparam logic [POS_W-1:0] POS_BITCNT = 5'd22;
    localparam logic [POS_W-1:0] POS_ALPHA  = 5'd26;
    localparam logic [POS_W-1:0] POS_DECIDE = 5'd31;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC  = 3'd2;
    localparam logic [2:0] ST_BAD_HDR    = 3'd3;
    localparam logic [2:0] ST_BAD_FOURCC = 3'd4;

    localparam logic [2:0] FMT_DXT1     = 3'd0;
    localparam logic [2:0] FMT_DXT3     = 3'd1;
    localparam logic [2:0] FMT_DXT5     = 3'd2;
    localparam logic [2:0] FMT_A8R8G8B8 = 3'd3;
    localparam logic [2:0] FMT_X8R8G8B8 = 3'd4;
    localparam logic [2:0] FMT_R5G6B5   = 3'd5;

    localparam int OPC_W = 29;

    // one classified file, size = op_a * op_b * op_c
    typedef struct packed {
        logic [2:0]       status;
        logic [2:0]       fmt;
        logic             comp;
        logic [31:0]      width;
        logic [31:0]      height;
        logic [31:0]      mips;
        logic [31:0]      op_a;
        logic [31:0]      op_b;
        logic [OPC_W-1:0] op_c;
    } t_job;

    // result word, first field in the highest bits
    typedef struct packed {
        logic        size_overflow;
        logic [31:0] payload_bytes;
        logic [31:0] mip_count;
        logic [31:0] height;
        logic [31:0] width;
        logic        compressed;
        logic [2:0]  fmt;
        logic [2:0]  status;
    } t_result;

endpackage

`default_nettype wire

[sv/dds_header_parser.sv]
// dds_header_parser: top level of the texture header parser
// depends on dhp_pkg, dhp_front, dhp_queue, dhp_back
`timescale 1ns / 1ps
`default_nettype none

// Takes a texture file as 32-bit little-endian words on s_axis, one word per
// cycle, with tlast on the final word. After the 32nd word (or an early tlast)
// one result goes out on m_axis; later words of the file are taken and dropped.
// The front takes a word every cycle while the two-entry queue has room. The
// back works on one result at a time: queue pop, width by height multiply,
// multiply by the bytes per block or pixel, output transfer; so a result waiting
// on m_axis stalls the input only once the queue has filled.

module dds_header_parser
    import dhp_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,   // word
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[2:0], format[5:3], compressed[6], width[38:7], height[70:39],
    // mip_count[102:71], payload_bytes[134:103], size_overflow[135]
    output logic [135:0]      m_axis_tdata
);

    logic    w_push, w_full, w_avail, w_pop;
    t_job    w_push_job, w_pop_job;
    t_result w_res;

    dhp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_word   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    dhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .o_avail (w_avail),
        .i_pop   (w_pop),
        .o_job   (w_pop_job)
    );

    dhp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (w_avail),
        .i_job   (w_pop_job),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_res)
    );

    assign m_axis_tdata = w_res;

    // an error result carries nothing but its status
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.status != ST_OK |-> m_axis_tdata[135:3] == '0)
        else $error("error result with nonzero fields");

    // a compressed result is a good dxt file
    a_comp_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.compressed |->
            w_res.status == ST_OK && (w_res.fmt == FMT_DXT1 || w_res.fmt == FMT_DXT3
            || w_res.fmt == FMT_DXT5))
        else $error("compressed flag on non-dxt result");

    // the queue is never written while full
    a_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue overrun");

    // a good result never reports zero mip levels
    a_mips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.status == ST_OK |-> w_res.mip_count != 32'd0)
        else $error("zero mip count on good result");

endmodule

`default_nettype wire

[sv/dhp_front.sv]
// dhp_front: takes header words, captures fields by position and classifies the file
// depends on dhp_pkg
`timescale 1ns / 1ps
`default_nettype none

module dhp_front
    import dhp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_word,
    input  wire logic        i_last,
    input  wire logic        i_q_full,
    output logic             o_push,
    output t_job             o_job
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_decided, n_decided;
    logic             r_magic_ok, r_hdr_ok, r_alpha;
    logic             r_flag_fourcc, r_flag_rgb;
    logic [31:0]      r_height, r_width, r_mips, r_fourcc, r_bitcnt;

    logic             w_accept;
    logic [32:0]      w_wsum, w_hsum;
    t_job             w_dec_job, w_short_job;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_wsum   = {1'b0, r_width} + 33'd3;
    assign w_hsum   = {1'b0, r_height} + 33'd3;

    always_comb begin
        w_short_job        = '0;
        w_short_job.status = ST_TOO_SHORT;
    end

    always_comb begin
        w_dec_job = '0;
        if (!r_magic_ok) begin
            w_dec_job.status = ST_BAD_MAGIC;
        end else if (!r_hdr_ok) begin
            w_dec_job.status = ST_BAD_HDR;
        end else if (r_flag_fourcc && r_fourcc != CC_DXT1 && r_fourcc != CC_DXT3
                     && r_fourcc != CC_DXT5) begin
            w_dec_job.status = ST_BAD_FOURCC;
        end else begin
            w_dec_job.status = ST_OK;
            w_dec_job.width  = r_width;
            w_dec_job.height = r_height;
            w_dec_job.mips   = (r_mips == 32'd0) ? 32'd1 : r_mips;
            if (r_flag_fourcc) begin
                w_dec_job.comp = 1'b1;
                w_dec_job.op_a = {1'b0, w_wsum[32:2]};
                w_dec_job.op_b = {1'b0, w_hsum[32:2]};
                if (r_fourcc == CC_DXT1) begin
                    w_dec_job.fmt  = FMT_DXT1;
                    w_dec_job.op_c = OPC_W'(8);
                end else if (r_fourcc == CC_DXT3) begin
                    w_dec_job.fmt  = FMT_DXT3;
                    w_dec_job.op_c = OPC_W'(16);
                end else begin
                    w_dec_job.fmt  = FMT_DXT5;
                    w_dec_job.op_c = OPC_W'(16);
                end
            end else if (r_flag_rgb) begin
                w_dec_job.op_a = r_width;
                w_dec_job.op_b = r_height;
                w_dec_job.op_c = r_bitcnt[31:3];
                if (r_bitcnt == 32'd32) begin
                    w_dec_job.fmt = r_alpha ? FMT_A8R8G8B8 : FMT_X8R8G8B8;
                end else if (r_bitcnt == 32'd16) begin
                    w_dec_job.fmt = FMT_R5G6B5;
                end else begin
                    w_dec_job.fmt = FMT_A8R8G8B8;
                end
            end else begin
                w_dec_job.fmt  = FMT_A8R8G8B8;
                w_dec_job.op_a = r_width;
                w_dec_job.op_b = r_height;
                w_dec_job.op_c = OPC_W'(4);
            end
        end
    end

    assign o_push = w_accept && !r_decided && (r_pos == POS_DECIDE || i_last);
    assign o_job  = (r_pos == POS_DECIDE) ? w_dec_job : w_short_job;

    always_comb begin
        n_pos     = r_pos;
        n_decided = r_decided;
        if (w_accept) begin
            if (!r_decided) begin
                if (r_pos == POS_DECIDE) begin
                    n_decided = 1'b1;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            if (i_last) begin
                n_pos     = '0;
                n_decided = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_decided <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_decided <= n_decided;
        end
    end

    // field capture, every field is rewritten before a decision
    always_ff @(posedge i_clk) begin
        if (w_accept && !r_decided) begin
            unique case (r_pos)
                POS_MAGIC:  r_magic_ok <= (i_word == MAGIC_DDS);
                POS_HDR:    r_hdr_ok   <= (i_word == HDR_BYTES);
                POS_HEIGHT: r_height   <= i_word;
                POS_WIDTH:  r_width    <= i_word;
                POS_MIPS:   r_mips     <= i_word;
                POS_FLAGS: begin
                    r_flag_fourcc <= i_word[FLAG_FOURCC_BIT];
                    r_flag_rgb    <= i_word[FLAG_RGB_BIT];
                end
                POS_FOURCC: r_fourcc   <= i_word;
                POS_BITCNT: r_bitcnt   <= i_word;
                POS_ALPHA:  r_alpha    <= (i_word != 32'd0);
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/dhp_queue.sv]
// dhp_queue: two-entry queue of classified files between front and back
// depends on dhp_pkg
`timescale 1ns / 1ps
`default_nettype none

module dhp_queue
    import dhp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    output logic      o_avail,
    input  wire logic i_pop,
    output t_job      o_job
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

[sv/dhp_back.sv]
// dhp_back: computes the payload size in two multiply steps and holds the result
// depends on dhp_pkg
`timescale 1ns / 1ps
`default_nettype none

module dhp_back
    import dhp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_avail,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_result   o_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL1 = 2'd1;
    localparam logic [1:0] S_MUL2 = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]        r_state, n_state;
    t_job              r_job;
    logic [63:0]       r_prod;
    t_result           r_out;
    logic [OPC_W+31:0] w_pc;
    logic              w_ovf;

    assign o_pop   = (r_state == S_IDLE) && i_avail;
    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_out;

    // low word of the product times the scale; high word only matters as nonzero
    assign w_pc  = r_prod[31:0] * r_job.op_c;
    assign w_ovf = ((r_job.op_c != '0) && (r_prod[63:32] != 32'd0))
                   || (w_pc[OPC_W+31:32] != '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_avail) n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_OUT;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == S_MUL1) begin
            r_prod <= r_job.op_a * r_job.op_b;
        end
        if (r_state == S_MUL2) begin
            r_out.status        <= r_job.status;
            r_out.fmt           <= r_job.fmt;
            r_out.compressed    <= r_job.comp;
            r_out.width         <= r_job.width;
            r_out.height        <= r_job.height;
            r_out.mip_count     <= r_job.mips;
            r_out.payload_bytes <= w_pc[31:0];
            r_out.size_overflow <= w_ovf;
        end
    end

endmodule

`default_nettype wire

[verif/dds_header_parser_tb.sv]
// dds_header_parser_tb: self-checking bench for the texture header parser
// drives word streams of whole files, predicts each header verdict and size
// depends on dhp_pkg and dds_header_parser
`timescale 1ns / 1ps

module dds_header_parser_tb;
    import dhp_pkg::*;

    localparam logic [31:0] FL_FOURCC = 32'd1 << FLAG_FOURCC_BIT;
    localparam logic [31:0] FL_RGB    = 32'd1 << FLAG_RGB_BIT;
    localparam logic [31:0] CC_DXT2   = 32'h3254_5844;

    class header_scoreboard;
        t_result     expected_headers[$];
        int          errors;
        logic [5:0]  word_pos;
        logic        decided, magic_ok, hdr_ok, alpha_seen;
        logic [31:0] img_h, img_w, img_mips, fmt_flags, pf_fourcc, pf_bits;

        function new();
            errors = 0;
            rearm();
        endfunction

        function void rearm();
            word_pos = '0;
            decided = 1'b0;
            magic_ok = 1'b0;
            hdr_ok = 1'b0;
            alpha_seen = 1'b0;
            img_h = '0;
            img_w = '0;
            img_mips = '0;
            fmt_flags = '0;
            pf_fourcc = '0;
            pf_bits = '0;
        endfunction

        function t_result classify_header();
            t_result     r;
            logic [32:0] cols, rows;
            logic [63:0] area;
            logic [31:0] unit_bytes;
            logic [95:0] total;
            r = '0;
            if (!magic_ok) begin
                r.status = ST_BAD_MAGIC;
                return r;
            end
            if (!hdr_ok) begin
                r.status = ST_BAD_HDR;
                return r;
            end
            cols = {1'b0, img_w};
            rows = {1'b0, img_h};
            unit_bytes = 32'd4;
            r.fmt = FMT_A8R8G8B8;
            if (fmt_flags[FLAG_FOURCC_BIT]) begin
                // block compressed: 4x4 pixel blocks
                r.compressed = 1'b1;
                cols = ({1'b0, img_w} + 33'd3) >> 2;
                rows = ({1'b0, img_h} + 33'd3) >> 2;
                unit_bytes = 32'd16;
                if (pf_fourcc == CC_DXT1) begin
                    r.fmt = FMT_DXT1;
                    unit_bytes = 32'd8;
                end else if (pf_fourcc == CC_DXT3) begin
                    r.fmt = FMT_DXT3;
                end else if (pf_fourcc == CC_DXT5) begin
                    r.fmt = FMT_DXT5;
                end else begin
                    r = '0;
                    r.status = ST_BAD_FOURCC;
                    return r;
                end
            end else if (fmt_flags[FLAG_RGB_BIT]) begin
                unit_bytes = pf_bits >> 3;
                if (pf_bits == 32'd32)
                    r.fmt = alpha_seen ? FMT_A8R8G8B8 : FMT_X8R8G8B8;
                else if (pf_bits == 32'd16)
                    r.fmt = FMT_R5G6B5;
                else
                    r.fmt = FMT_A8R8G8B8;
            end
            area = cols * rows;
            total = area * unit_bytes;
            r.status = ST_OK;
            r.width = img_w;
            r.height = img_h;
            r.mip_count = (img_mips == '0) ? 32'd1 : img_mips;
            r.payload_bytes = total[31:0];
            r.size_overflow = |total[95:32];
            return r;
        endfunction

        function void note_word(logic [31:0] w, logic l);
            t_result r;
            if (!decided) begin
                case (word_pos)
                    POS_MAGIC:  magic_ok = (w == MAGIC_DDS);
                    POS_HDR:    hdr_ok = (w == HDR_BYTES);
                    POS_HEIGHT: img_h = w;
                    POS_WIDTH:  img_w = w;
                    POS_MIPS:   img_mips = w;
                    POS_FLAGS:  fmt_flags = w;
                    POS_FOURCC: pf_fourcc = w;
                    POS_BITCNT: pf_bits = w;
                    POS_ALPHA:  alpha_seen = (w != '0);
                    default: ;
                endcase
                if (word_pos >= POS_DECIDE) begin
                    expected_headers.push_back(classify_header());
                    decided = 1'b1;
                end else if (l) begin
                    r = '0;
                    r.status = ST_TOO_SHORT;
                    expected_headers.push_back(r);
                end else begin
                    word_pos = word_pos + 6'd1;
                end
            end
            if (l)
                rearm();
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_headers.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_headers.pop_front();
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("format", 32'(want.fmt), 32'(got.fmt));
            check_field("compressed", 32'(want.compressed), 32'(got.compressed));
            check_field("width", want.width, got.width);
            check_field("height", want.height, got.height);
            check_field("mip_count", want.mip_count, got.mip_count);
            check_field("payload_bytes", want.payload_bytes, got.payload_bytes);
            check_field("size_overflow", 32'(want.size_overflow),
                        32'(got.size_overflow));
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [31:0]   s_axis_tdata = '0;   // word
    logic          s_axis_tlast = 1'b0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    // status, format, compressed, width, height, mip_count, payload_bytes,
    // size_overflow
    logic [135:0]  m_axis_tdata;

    header_scoreboard sb = new();
    logic [31:0]      file_words[0:47];
    int               src_idle_pct = 0;
    int               stall_pct = 0;
    int               total_words = 0;

    dds_header_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            sb.check_result(m_axis_tdata);
    end

    task automatic send_word(input logic [31:0] w, input logic l);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        s_axis_tlast <= l;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1)
            @(posedge i_clk);
        sb.note_word(w, l);
        @(negedge i_clk);
    endtask

    task automatic send_file(input int len);
        for (int i = 0; i < len; i++)
            send_word(file_words[i], i == len - 1);
        total_words += len;
    endtask

    task automatic build_file(input logic [31:0] magic, input logic [31:0] hsize,
                              input logic [31:0] h, input logic [31:0] w,
                              input logic [31:0] mips, input logic [31:0] flags,
                              input logic [31:0] fourcc, input logic [31:0] bits,
                              input logic [31:0] amask);
        for (int i = 0; i < 48; i++)
            file_words[i] = $urandom;
        file_words[POS_MAGIC] = magic;
        file_words[POS_HDR] = hsize;
        file_words[POS_HEIGHT] = h;
        file_words[POS_WIDTH] = w;
        file_words[POS_MIPS] = mips;
        file_words[POS_FLAGS] = flags;
        file_words[POS_FOURCC] = fourcc;
        file_words[POS_BITCNT] = bits;
        file_words[POS_ALPHA] = amask;
    endtask

    task automatic random_file();
        logic [31:0] magic, hsize, h, w, mips, flags, fourcc, bits, amask;
        int          len, pick;
        magic = ($urandom_range(9) == 0) ? $urandom : MAGIC_DDS;
        hsize = ($urandom_range(9) == 0) ? $urandom : HDR_BYTES;
        h = ($urandom_range(99) < 85) ? $urandom_range(4096) : $urandom;
        w = ($urandom_range(99) < 85) ? $urandom_range(4096) : $urandom;
        mips = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
        flags = $urandom;
        pick = $urandom_range(3);
        flags[FLAG_FOURCC_BIT] = (pick == 0 || pick == 2);
        flags[FLAG_RGB_BIT] = (pick == 1 || pick == 2);
        case ($urandom_range(3))
            0: fourcc = CC_DXT1;
            1: fourcc = CC_DXT3;
            2: fourcc = CC_DXT5;
            default: fourcc = $urandom;
        endcase
        case ($urandom_range(4))
            0: bits = 32'd32;
            1: bits = 32'd16;
            2: bits = 32'd24;
            3: bits = 32'd8;
            default: bits = $urandom;
        endcase
        amask = $urandom_range(1) ? 32'd0 : $urandom;
        build_file(magic, hsize, h, w, mips, flags, fourcc, bits, amask);
        // plain noise with no header structure
        if ($urandom_range(9) == 0) begin
            for (int i = 0; i < 48; i++)
                file_words[i] = $urandom;
        end
        pick = $urandom_range(99);
        if (pick < 60)
            len = 32;
        else if (pick < 75)
            len = $urandom_range(40, 33);
        else
            len = $urandom_range(31, 1);
        send_file(len);
    endtask

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed files
        build_file(MAGIC_DDS, HDR_BYTES, 1, 1, 0, FL_FOURCC, CC_DXT1, 0, 0);
        send_file(32);
        build_file(MAGIC_DDS, HDR_BYTES, '1, '1, 5, FL_FOURCC, CC_DXT3, 0, 0);
        send_file(32);
        build_file(MAGIC_DDS, HDR_BYTES, 7, 5, 3, FL_FOURCC, CC_DXT5, 0, 0);
        send_file(36);
        build_file(MAGIC_DDS, HDR_BYTES, 64, 64, 1, FL_FOURCC, CC_DXT2, 0, 0);
        send_file(32);
        build_file(MAGIC_DDS, HDR_BYTES, 8, 8, 0, FL_FOURCC | FL_RGB, CC_DXT1, 32, 0);
        send_file(33);
        build_file(MAGIC_DDS, HDR_BYTES, 3, 5, 2, FL_RGB, 0, 32, 32'hff00_0000);
        send_file(32);
        build_file(MAGIC_DDS, HDR_BYTES, 3, 5, 2, FL_RGB, 0, 32, 0);
        send_file(32);
        build_file(MAGIC_DDS, HDR_BYTES, 9, 11, 4, FL_RGB, 0, 16, 0);
        send_file(32);
        build_file(MAGIC_DDS, HDR_BYTES, 9, 11, 4, FL_RGB, 0, 24, 1);
        send_file(32);
        build_file(MAGIC_DDS, HDR_BYTES, '1, '1, '1, FL_RGB, 0, '1, '1);
        send_file(32);
        build_file(MAGIC_DDS, HDR_BYTES, 0, 0, 0, '0, 0, 0, 0);
        send_file(32);
        build_file(MAGIC_DDS, HDR_BYTES, '1, 0, '1, ~(FL_FOURCC | FL_RGB), 0, 0, 0);
        send_file(40);
        build_file(~MAGIC_DDS, 0, 4, 4, 1, FL_FOURCC, CC_DXT1, 0, 0);
        send_file(32);
        build_file(MAGIC_DDS, 32'd128, 4, 4, 1, FL_FOURCC, CC_DXT1, 0, 0);
        send_file(32);
        build_file(MAGIC_DDS, HDR_BYTES, 4, 4, 1, FL_FOURCC, CC_DXT1, 0, 0);
        send_file(1);
        send_file(31);
        send_file(2);

        // random files under four flow-control phases
        total_words = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 67;
                    stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    stall_pct = 67;
                end
                default: begin
                    src_idle_pct = 11;
                    stall_pct = 11;
                end
            endcase
            while (total_words < (phase + 1) * 350)
                random_file();
        end
        s_axis_tvalid <= 1'b0;

        while (sb.expected_headers.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_headers.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
